[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types, constants and byte classification for the utf-8 stream decoder
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int CP_W             = 21;
    localparam int COUNT_W          = 3;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // class of one raw byte
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_CONT  = 3'd4,
        CLS_BAD   = 3'd5
    } byte_class_t;

    // work handed from the front to the back: a run of invalid results for a
    // broken sequence, then an optional closing result
    typedef struct packed {
        logic [1:0]         inv_cnt;
        logic               has_tail;
        logic               tail_valid;
        logic [CP_W-1:0]    tail_cp;
        logic [COUNT_W-1:0] tail_count;
    } job_t;

    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        priority casez (b)
            8'b0???_????: c = CLS_ASCII;
            8'b10??_????: c = CLS_CONT;
            8'b110?_????: c = CLS_LEAD2;
            8'b1110_????: c = CLS_LEAD3;
            8'b1111_0???: c = CLS_LEAD4;
            default:      c = CLS_BAD;
        endcase
        return c;
    endfunction

endpackage

[rtl/u8d_front.sv]
// ----------------------------------------------------------------------------
// u8d_front
// takes one byte per cycle unless q_full, tracks the pending sequence and builds jobs
// ----------------------------------------------------------------------------
module u8d_front
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       in_stall,
    output logic       push,
    output job_t       push_job
);

    logic [CP_W-1:0] partial_value_reg, partial_value_next;
    logic [1:0]      needed_reg, needed_next;
    logic [1:0]      taken_reg, taken_next;

    byte_class_t     cls;
    logic            accept;
    logic            pending;
    logic [CP_W-1:0] shifted;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign cls      = classify(data_byte);
    assign pending  = (needed_reg != 2'd0);
    assign shifted  = {partial_value_reg[CP_W-7:0], data_byte[5:0]};

    always_comb
    begin
        partial_value_next = partial_value_reg;
        needed_next        = needed_reg;
        taken_next         = taken_reg;
        push_job           = '0;

        if (accept)
        begin
            if (pending && (cls == CLS_CONT))
            begin
                partial_value_next = shifted;
                taken_next         = taken_reg + 2'd1;
                needed_next        = needed_reg - 2'd1;
                if (needed_reg == 2'd1)
                begin
                    push_job.has_tail   = 1'b1;
                    push_job.tail_valid = 1'b1;
                    push_job.tail_cp    = shifted;
                    push_job.tail_count = {1'b0, taken_reg} + COUNT_W'(2);
                    partial_value_next  = '0;
                    taken_next          = 2'd0;
                end
            end
            else
            begin
                // broken sequence: the lead and every continuation taken
                if (pending)
                begin
                    push_job.inv_cnt = taken_reg + 2'd1;
                end
                partial_value_next = '0;
                needed_next        = 2'd0;
                taken_next         = 2'd0;
                unique case (cls)
                    CLS_ASCII:
                    begin
                        push_job.has_tail   = 1'b1;
                        push_job.tail_valid = 1'b1;
                        push_job.tail_cp    = {{(CP_W-8){1'b0}}, data_byte};
                        push_job.tail_count = COUNT_W'(1);
                    end
                    CLS_LEAD2:
                    begin
                        partial_value_next = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                        needed_next        = 2'd1;
                    end
                    CLS_LEAD3:
                    begin
                        partial_value_next = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                        needed_next        = 2'd2;
                    end
                    CLS_LEAD4:
                    begin
                        partial_value_next = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                        needed_next        = 2'd3;
                    end
                    default:
                    begin
                        push_job.has_tail   = 1'b1;
                        push_job.tail_valid = 1'b0;
                        push_job.tail_cp    = '0;
                        push_job.tail_count = COUNT_W'(1);
                    end
                endcase
            end
        end
    end

    assign push = accept && (push_job.has_tail || (push_job.inv_cnt != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_value_reg <= '0;
            needed_reg        <= 2'd0;
            taken_reg         <= 2'd0;
        end
        else
        begin
            partial_value_reg <= partial_value_next;
            needed_reg        <= needed_next;
            taken_reg         <= taken_next;
        end
    end

`ifndef SYNTHESIS
    // taken plus still needed never exceeds three continuations
    a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, needed_reg} + {1'b0, taken_reg}) <= 3'd3)
        else $error("sequence length bookkeeping broken");
`endif

endmodule

[rtl/u8d_queue.sv]
// ----------------------------------------------------------------------------
// u8d_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("job queue overflow");

    a_empty_queue_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (head_job.has_tail || (head_job.inv_cnt != 2'd0)))
        else $error("empty job in queue");
`endif

endmodule

[rtl/u8d_back.sv]
// ----------------------------------------------------------------------------
// u8d_back
// expands each job into result transfers into an output register, one per unstalled cycle
// ----------------------------------------------------------------------------
module u8d_back
    import u8d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  job_t               head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CP_W-1:0]    code_point,
    output logic               is_valid,
    output logic [COUNT_W-1:0] byte_count,
    output logic               last_of_run
);

    logic               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]    code_point_reg, code_point_next;
    logic               is_valid_reg, is_valid_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic               last_reg, last_next;
    logic [1:0]         inv_sent_reg, inv_sent_next;
    logic               load;
    logic               inv_last;

    assign load     = !out_valid_reg || !out_stall;
    assign inv_last = ((inv_sent_reg + 2'd1) == head_job.inv_cnt);

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        code_point_next = code_point_reg;
        is_valid_next   = is_valid_reg;
        byte_count_next = byte_count_reg;
        last_next       = last_reg;
        inv_sent_next   = inv_sent_reg;
        pop             = 1'b0;

        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (inv_sent_reg < head_job.inv_cnt)
                begin
                    code_point_next = '0;
                    is_valid_next   = 1'b0;
                    byte_count_next = COUNT_W'(1);
                    last_next       = inv_last && !head_job.has_tail;
                    if (inv_last && !head_job.has_tail)
                    begin
                        pop           = 1'b1;
                        inv_sent_next = 2'd0;
                    end
                    else
                    begin
                        inv_sent_next = inv_sent_reg + 2'd1;
                    end
                end
                else
                begin
                    code_point_next = head_job.tail_cp;
                    is_valid_next   = head_job.tail_valid;
                    byte_count_next = head_job.tail_count;
                    last_next       = 1'b1;
                    pop             = 1'b1;
                    inv_sent_next   = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            inv_sent_reg  <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            inv_sent_reg  <= inv_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_point_reg <= code_point_next;
        is_valid_reg   <= is_valid_next;
        byte_count_reg <= byte_count_next;
        last_reg       <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign code_point  = code_point_reg;
    assign is_valid    = is_valid_reg;
    assign byte_count  = byte_count_reg;
    assign last_of_run = last_reg;

`ifndef SYNTHESIS
    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_valid_reg) |->
            (code_point_reg == '0) && (byte_count_reg == COUNT_W'(1)))
        else $error("invalid result with payload");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            (byte_count_reg != '0) && (byte_count_reg <= COUNT_W'(4)))
        else $error("byte count out of range");
`endif

endmodule

[rtl/utf8_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// utf-8 byte stream to code point decoder with a decoupled front and back
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall | data_byte
//  out     | source    | out_valid/out_stall | code_point, is_valid, byte_count,
//          |           |                     | last_of_run
//
//  one byte is taken per cycle while the job queue has room
//  each result is loaded into the output register on its own, so a broken
//  sequence (up to four results from one byte) holds the back for each one
//  a byte's result goes from the front via a queue slot into the output reg
//  reset clears the pending sequence, the queue pointers and the output valid
//  in_stall rises only when the queue is full; out_stall just holds the
//  output register and the head job
//
module utf8_stream_decoder_core
    import u8d_pkg::*;
#(
    // jobs buffered between the front and the back, at least two
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CP_W-1:0]    code_point,
    output logic               is_valid,
    output logic [COUNT_W-1:0] byte_count,
    output logic               last_of_run
);

    // front to queue
    logic push;
    job_t push_job;
    logic q_full;

    // queue to back
    logic head_valid;
    job_t head_job;
    logic pop;

    // front: classifies each byte and keeps the pending sequence state
    u8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .q_full    (q_full),
        .in_stall  (in_stall),
        .push      (push),
        .push_job  (push_job)
    );

    // queue: lets the front run on while the back drains a burst
    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    // back: turns each job into its result transfers
    u8d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_point  (code_point),
        .is_valid    (is_valid),
        .byte_count  (byte_count),
        .last_of_run (last_of_run)
    );

endmodule
